// File: hdl/assert_macros.svh
// Assertion macros used by the checker file mmcs_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/mmcs_pkg.sv
// Shared constants, opcodes and controller command struct for the contrast stretch.
// No dependencies.
package mmcs_pkg;

    localparam int PIX_W  = 16;
    localparam int OUT_W  = 8;
    localparam int OP_W   = 2;
    localparam int DIFF_W = PIX_W + 1;
    localparam int PROD_W = PIX_W + OUT_W;
    localparam int STEPS  = OUT_W;
    localparam int DEN_W  = PIX_W + STEPS - 1;
    localparam int CNT_W  = $clog2(STEPS);

    localparam logic [OP_W-1:0] OP_MEASURE = 2'd0;
    localparam logic [OP_W-1:0] OP_RESCALE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic signed [PIX_W-1:0] MIN_RESET = 16'sd32767;
    localparam logic signed [PIX_W-1:0] MAX_RESET = 16'sd0;
    localparam logic [OUT_W-1:0]        OUT_FULL  = 8'd255;

    typedef struct packed {
        logic measure;
        logic clear;
        logic capture;
        logic mul;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

endpackage

// File: hdl/mmcs_ifs.sv
// Valid/ready channel interfaces for pixel input and scaled result output.
// Depends on mmcs_pkg.
interface mmcs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [mmcs_pkg::OP_W-1:0]            opcode;
    logic signed [mmcs_pkg::PIX_W-1:0]    pixel_value;

    modport source (output valid, output opcode, output pixel_value, input ready);
    modport sink   (input valid, input opcode, input pixel_value, output ready);
endinterface

interface mmcs_out_if;
    logic                          valid;
    logic                          ready;
    logic [mmcs_pkg::OUT_W-1:0]    scaled_pixel;
    logic                          range_zero;

    modport source (output valid, output scaled_pixel, output range_zero, input ready);
    modport sink   (input valid, input scaled_pixel, input range_zero, output ready);
endinterface

// File: hdl/mmcs_datapath.sv
// Datapath: running min/max, multiply by 255, restoring divider, output register.
// Depends on mmcs_pkg; driven by mmcs_ctrl commands.
module mmcs_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mmcs_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [mmcs_pkg::PIX_W-1:0] i_pixel_value,
    output logic [mmcs_pkg::OUT_W-1:0]        o_scaled_pixel,
    output logic                              o_range_zero
);
    import mmcs_pkg::*;

    logic signed [PIX_W-1:0]  r_min, r_max, n_min, n_max;
    logic signed [DIFF_W-1:0] r_diff, r_range;
    logic [PROD_W-1:0]        r_rem;
    logic [DEN_W-1:0]         r_den;
    logic [OUT_W-1:0]         r_quo;
    logic                     r_zero, r_low, r_high;
    logic [OUT_W-1:0]         r_scaled;
    logic                     r_rzero;

    logic signed [DIFF_W-1:0] w_diff_in, w_range_in;
    logic [PROD_W-1:0]        w_prod, w_den_ext, w_trial;
    logic                     w_ge;

    assign w_diff_in  = {i_pixel_value[PIX_W-1], i_pixel_value} - {r_min[PIX_W-1], r_min};
    assign w_range_in = {r_max[PIX_W-1], r_max} - {r_min[PIX_W-1], r_min};
    // diff * 255 as (diff << 8) - diff, valid only when 0 < diff < range
    assign w_prod     = {r_diff[PIX_W-1:0], {OUT_W{1'b0}}}
                      - {{OUT_W{1'b0}}, r_diff[PIX_W-1:0]};
    assign w_den_ext  = {{(PROD_W-DEN_W){1'b0}}, r_den};
    assign w_ge       = r_rem >= w_den_ext;
    assign w_trial    = r_rem - w_den_ext;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_cmd.clear) begin
            n_min = MIN_RESET;
            n_max = MAX_RESET;
        end else if (i_cmd.measure) begin
            if (i_pixel_value < r_min) begin
                n_min = i_pixel_value;
            end
            if (i_pixel_value > r_max) begin
                n_max = i_pixel_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_diff  <= w_diff_in;
            r_range <= w_range_in;
        end
        if (i_cmd.mul) begin
            r_rem  <= w_prod;
            r_den  <= {r_range[PIX_W-1:0], {(STEPS-1){1'b0}}};
            r_quo  <= '0;
            r_zero <= r_range[DIFF_W-1] || (r_range == '0);
            r_low  <= r_diff[DIFF_W-1] || (r_diff == '0);
            r_high <= r_diff >= r_range;
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= w_trial;
            end
            r_quo <= {r_quo[OUT_W-2:0], w_ge};
            r_den <= r_den >> 1;
        end
        if (i_cmd.out_load) begin
            r_rzero <= r_zero;
            if (r_zero || r_low) begin
                r_scaled <= '0;
            end else if (r_high) begin
                r_scaled <= OUT_FULL;
            end else begin
                r_scaled <= r_quo;
            end
        end
    end

    assign o_scaled_pixel = r_scaled;
    assign o_range_zero   = r_rzero;

endmodule

// File: hdl/mmcs_ctrl.sv
// Controller: handshakes, opcode decode, divider step count, output valid.
// Depends on mmcs_pkg; commands mmcs_datapath.
module mmcs_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [mmcs_pkg::OP_W-1:0]  i_opcode,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output mmcs_pkg::t_dp_cmd          o_cmd
);
    import mmcs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.measure  = w_accept && (i_opcode == OP_MEASURE);
        o_cmd.clear    = w_accept && (i_opcode == OP_CLEAR);
        o_cmd.capture  = w_accept && (i_opcode == OP_RESCALE);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/min_max_contrast_stretch.sv
// Top level of the two-pass min/max contrast stretch.
// Depends on mmcs_pkg, mmcs_ifs, mmcs_ctrl and mmcs_datapath.
//
// Usage:
//   i_pix carries one transaction per item: opcode and a signed 16-bit pixel.
//   Opcode measure folds the pixel into the running min and max; clear restores
//   min 32767 and max 0; rescale yields one transaction on o_res. Opcode 3 is
//   dropped without effect.
//   Measure, clear and unused items are taken back to back.
//   A rescale item runs in steps: capture, one multiply by 255, eight
//   restoring divider steps (one quotient bit each), then the output register
//   load. The result is on o_res the cycle after that; i_pix is not ready
//   during the rescale.
//   o_res is a registered output, so the next item is taken while a result
//   waits. If the receiver stalls, a second rescale holds in its last step
//   until the output register frees.
//   Synchronous active-low reset empties the output and restores the min/max.
//   range_zero flags max - min not positive; scaled_pixel is then 0.
module min_max_contrast_stretch (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mmcs_in_if.sink           i_pix,
    mmcs_out_if.source        o_res
);
    import mmcs_pkg::*;

    t_dp_cmd w_cmd;

    mmcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_opcode    (i_pix.opcode),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd)
    );

    mmcs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_pixel_value  (i_pix.pixel_value),
        .o_scaled_pixel (o_res.scaled_pixel),
        .o_range_zero   (o_res.range_zero)
    );

endmodule

// File: hdl/mmcs_checker.sv
// Port-level checks for min_max_contrast_stretch, bound to the top level.
// Depends on mmcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmcs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic [mmcs_pkg::OP_W-1:0]  i_in_opcode,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [mmcs_pkg::OUT_W-1:0] i_scaled_pixel,
    input logic                       i_range_zero
);
    import mmcs_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `ASSERT_IMPLIES(a_rz_zero, i_clk, i_rst_n, i_out_valid && i_range_zero, i_scaled_pixel == '0)
    `ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_opcode == OP_RESCALE), !i_in_ready)
    `ASSERT_NEXT(a_fast, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_opcode != OP_RESCALE), i_in_ready)

endmodule

bind min_max_contrast_stretch mmcs_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pix.valid),
    .i_in_ready     (i_pix.ready),
    .i_in_opcode    (i_pix.opcode),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_scaled_pixel (o_res.scaled_pixel),
    .i_range_zero   (o_res.range_zero)
);
